// ===== hw/rtl/dtc_pkg.sv =====
// Shared constants, register codes and the config struct of the depth-to-color map.
// No dependencies; every other file of the block uses it by scoped names.
package dtc_pkg;

    localparam int DEPTH_BITS = 16;
    localparam int S_TDATA_W  = ((DEPTH_BITS + 7) / 8) * 8;
    localparam int CH_W       = 8;
    localparam int M_TDATA_W  = 3 * CH_W;

    localparam int DCFG_W     = 15;
    localparam int HUE_W      = 9;
    localparam int LVL_W      = 9;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 15;
    localparam int EXT_W      = (DEPTH_BITS > DCFG_W) ? DEPTH_BITS : DCFG_W;

    localparam int TURN_W     = 24;
    localparam int Q_W        = 24;
    localparam int PROD_W     = TURN_W + Q_W;
    localparam int LVLQ_W     = 17;
    localparam int ROUND_LSB  = 16;

    localparam int DEG_TURN   = 360;
    localparam int DEG_THIRD  = 120;

    localparam int DIV_STEPS   = 2;
    localparam int DIV_STAGES  = Q_W / DIV_STEPS;
    localparam int HUE_STAGES  = 5;
    localparam int CHAN_STAGES = DIV_STAGES + 3;
    localparam int PIPE_STAGES = HUE_STAGES + CHAN_STAGES;

    localparam logic [IDX_W-1:0] REG_DEPTH_LOW  = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEPTH_HIGH = 3'd1;
    localparam logic [IDX_W-1:0] REG_HUE_LOW    = 3'd2;
    localparam logic [IDX_W-1:0] REG_HUE_HIGH   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SATURATION = 3'd4;
    localparam logic [IDX_W-1:0] REG_LIGHTNESS  = 3'd5;

    localparam logic [DCFG_W-1:0] RST_DEPTH_LOW  = 15'd32;
    localparam logic [DCFG_W-1:0] RST_DEPTH_HIGH = 15'd2080;
    localparam logic [HUE_W-1:0]  RST_HUE_LOW    = 9'd0;
    localparam logic [HUE_W-1:0]  RST_HUE_HIGH   = 9'd250;
    localparam logic [LVL_W-1:0]  RST_SATURATION = 9'd256;
    localparam logic [LVL_W-1:0]  RST_LIGHTNESS  = 9'd128;

    localparam logic [LVL_W-1:0]  LVL_ONE  = 9'd256;
    localparam logic [LVL_W-1:0]  LVL_HALF = 9'd128;

    typedef struct packed {
        logic [DCFG_W-1:0]       depth_low;
        logic [DCFG_W-1:0]       depth_high;
        logic                    empty;
        logic [DCFG_W-1:0]       den;
        logic [HUE_W-1:0]        hue_low;
        logic signed [HUE_W:0]   hue_diff;
        logic [TURN_W-1:0]       turn;
        logic [TURN_W-1:0]       third;
        logic [Q_W-1:0]          a_gain;
        logic [Q_W-1:0]          n_base;
    } t_map_cfg;

endpackage

// ===== hw/rtl/dtc_cfg.sv =====
// Configuration registers and the quantities derived from them (window, turn, HSL levels).
// Depends on dtc_pkg.
module dtc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [dtc_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [dtc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output dtc_pkg::t_map_cfg                o_cfg
);

    logic [dtc_pkg::DCFG_W-1:0] r_depth_low;
    logic [dtc_pkg::DCFG_W-1:0] r_depth_high;
    logic [dtc_pkg::HUE_W-1:0]  r_hue_low;
    logic [dtc_pkg::HUE_W-1:0]  r_hue_high;
    logic [dtc_pkg::LVL_W-1:0]  r_saturation;
    logic [dtc_pkg::LVL_W-1:0]  r_lightness;

    logic [dtc_pkg::LVL_W-1:0]    w_sat;
    logic [dtc_pkg::LVL_W-1:0]    w_lit;
    logic [2*dtc_pkg::LVL_W-1:0]  w_ls;
    logic [dtc_pkg::LVLQ_W-1:0]   w_q;
    logic [dtc_pkg::LVLQ_W-1:0]   w_p;
    logic [dtc_pkg::LVLQ_W-1:0]   w_qp;
    logic                         w_empty;
    logic [dtc_pkg::DCFG_W-1:0]   w_den;

    logic [dtc_pkg::LVLQ_W-1:0]   r_p;
    logic [dtc_pkg::LVLQ_W-1:0]   r_qp;
    logic [dtc_pkg::DCFG_W-1:0]   r_den;
    logic [dtc_pkg::Q_W-1:0]      r_a_gain;
    logic [dtc_pkg::Q_W-1:0]      r_n_base;
    logic [dtc_pkg::TURN_W-1:0]   r_turn;
    logic [dtc_pkg::TURN_W-1:0]   r_third;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_low  <= dtc_pkg::RST_DEPTH_LOW;
            r_depth_high <= dtc_pkg::RST_DEPTH_HIGH;
            r_hue_low    <= dtc_pkg::RST_HUE_LOW;
            r_hue_high   <= dtc_pkg::RST_HUE_HIGH;
            r_saturation <= dtc_pkg::RST_SATURATION;
            r_lightness  <= dtc_pkg::RST_LIGHTNESS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dtc_pkg::REG_DEPTH_LOW:  r_depth_low  <= i_cfg_data[dtc_pkg::DCFG_W-1:0];
                dtc_pkg::REG_DEPTH_HIGH: r_depth_high <= i_cfg_data[dtc_pkg::DCFG_W-1:0];
                dtc_pkg::REG_HUE_LOW:    r_hue_low    <= i_cfg_data[dtc_pkg::HUE_W-1:0];
                dtc_pkg::REG_HUE_HIGH:   r_hue_high   <= i_cfg_data[dtc_pkg::HUE_W-1:0];
                dtc_pkg::REG_SATURATION: r_saturation <= i_cfg_data[dtc_pkg::LVL_W-1:0];
                dtc_pkg::REG_LIGHTNESS:  r_lightness  <= i_cfg_data[dtc_pkg::LVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_sat = (r_saturation > dtc_pkg::LVL_ONE) ? dtc_pkg::LVL_ONE : r_saturation;
        w_lit = (r_lightness > dtc_pkg::LVL_ONE) ? dtc_pkg::LVL_ONE : r_lightness;
        w_ls  = {9'b0, w_lit} * {9'b0, w_sat};
        if (w_lit < dtc_pkg::LVL_HALF) begin
            w_q = dtc_pkg::LVLQ_W'({1'b0, w_lit, 8'b0} + w_ls);
        end else begin
            w_q = dtc_pkg::LVLQ_W'({1'b0, w_lit, 8'b0} + {1'b0, w_sat, 8'b0} - w_ls);
        end
        w_p  = dtc_pkg::LVLQ_W'({w_lit, 9'b0} - {1'b0, w_q});
        w_qp = w_q - w_p;
        w_empty = (r_depth_high <= r_depth_low);
        w_den   = w_empty ? dtc_pkg::DCFG_W'(1) : (r_depth_high - r_depth_low);

        o_cfg.depth_low  = r_depth_low;
        o_cfg.depth_high = r_depth_high;
        o_cfg.empty      = w_empty;
        o_cfg.den        = w_den;
        o_cfg.hue_low    = r_hue_low;
        o_cfg.hue_diff   = $signed({1'b0, r_hue_high}) - $signed({1'b0, r_hue_low});
        o_cfg.turn       = r_turn;
        o_cfg.third      = r_third;
        o_cfg.a_gain     = r_a_gain;
        o_cfg.n_base     = r_n_base;
    end

    always_ff @(posedge i_clk) begin
        r_p      <= w_p;
        r_qp     <= w_qp;
        r_den    <= w_den;
        // 255*x as (x << 8) - x
        r_a_gain <= dtc_pkg::Q_W'({r_qp, 8'b0} - {8'b0, r_qp});
        r_n_base <= dtc_pkg::Q_W'({r_p, 8'b0} - {8'b0, r_p} + 25'd32768);
        r_turn   <= dtc_pkg::TURN_W'(r_den) * dtc_pkg::TURN_W'(dtc_pkg::DEG_TURN);
        r_third  <= dtc_pkg::TURN_W'(r_den) * dtc_pkg::TURN_W'(dtc_pkg::DEG_THIRD);
    end

    a_q_ge_p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q >= w_p)
        else $error("HSL level q below p");

    a_lit_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_index == dtc_pkg::REG_LIGHTNESS
        |=> r_lightness == $past(i_cfg_data[dtc_pkg::LVL_W-1:0]))
        else $error("lightness write lost");

endmodule

// ===== hw/rtl/dtc_hue.sv =====
// Front pipeline: clamp, linear hue map, wrap to one turn and the three channel positions.
// Five register stages; depends on dtc_pkg.
module dtc_hue (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [dtc_pkg::DEPTH_BITS-1:0]    i_depth,
    input  dtc_pkg::t_map_cfg                 i_cfg,
    output logic [dtc_pkg::TURN_W-1:0]        o_pos_r,
    output logic [dtc_pkg::TURN_W-1:0]        o_pos_g,
    output logic [dtc_pkg::TURN_W-1:0]        o_pos_b
);

    localparam int M2_W = dtc_pkg::TURN_W + 2;

    logic [dtc_pkg::EXT_W-1:0]  w_depth;
    logic [dtc_pkg::DCFG_W-1:0] w_clamp;
    logic [dtc_pkg::DCFG_W-1:0] n_doff;
    logic [dtc_pkg::DCFG_W-1:0] r_doff;

    logic [dtc_pkg::TURN_W-1:0] n_m1;
    logic signed [M2_W-1:0]     n_m2;
    logic [dtc_pkg::TURN_W-1:0] r_m1;
    logic signed [M2_W-1:0]     r_m2;

    logic signed [M2_W-1:0]     n_hsum;
    logic [dtc_pkg::TURN_W-1:0] r_h;
    logic [dtc_pkg::TURN_W-1:0] r_hpos;

    logic [dtc_pkg::TURN_W:0]   w_sum_r;
    logic [dtc_pkg::TURN_W-1:0] n_pos_r;
    logic [dtc_pkg::TURN_W-1:0] n_pos_b;
    logic [dtc_pkg::TURN_W-1:0] r_pos_r;
    logic [dtc_pkg::TURN_W-1:0] r_pos_g;
    logic [dtc_pkg::TURN_W-1:0] r_pos_b;

    always_comb begin
        w_depth = dtc_pkg::EXT_W'(i_depth);
        if (w_depth < dtc_pkg::EXT_W'(i_cfg.depth_low)) begin
            w_clamp = i_cfg.depth_low;
        end else if (w_depth > dtc_pkg::EXT_W'(i_cfg.depth_high)) begin
            w_clamp = i_cfg.depth_high;
        end else begin
            w_clamp = w_depth[dtc_pkg::DCFG_W-1:0];
        end
        n_doff = i_cfg.empty ? '0 : (w_clamp - i_cfg.depth_low);

        n_m1 = dtc_pkg::TURN_W'(i_cfg.hue_low) * dtc_pkg::TURN_W'(i_cfg.den);
        n_m2 = M2_W'($signed({1'b0, r_doff})) * M2_W'(i_cfg.hue_diff);

        n_hsum = $signed({2'b0, r_m1}) + r_m2;

        w_sum_r = {1'b0, r_hpos} + {1'b0, i_cfg.third};
        if (w_sum_r >= {1'b0, i_cfg.turn}) begin
            n_pos_r = dtc_pkg::TURN_W'(w_sum_r - {1'b0, i_cfg.turn});
        end else begin
            n_pos_r = w_sum_r[dtc_pkg::TURN_W-1:0];
        end
        if (r_hpos >= i_cfg.third) begin
            n_pos_b = r_hpos - i_cfg.third;
        end else begin
            n_pos_b = r_hpos + (i_cfg.turn - i_cfg.third);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_doff  <= n_doff;
            r_m1    <= n_m1;
            r_m2    <= n_m2;
            // hue is never negative and stays below two turns
            r_h     <= n_hsum[dtc_pkg::TURN_W-1:0];
            r_hpos  <= (r_h >= i_cfg.turn) ? (r_h - i_cfg.turn) : r_h;
            r_pos_r <= n_pos_r;
            r_pos_g <= r_hpos;
            r_pos_b <= n_pos_b;
        end
    end

    assign o_pos_r = r_pos_r;
    assign o_pos_g = r_pos_g;
    assign o_pos_b = r_pos_b;

endmodule

// ===== hw/rtl/dtc_chan.sv =====
// One color channel: HSL segment select, gain multiply, pipelined restoring divide
// by the turn and final rounding. Fifteen register stages; depends on dtc_pkg.
module dtc_chan (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [dtc_pkg::TURN_W-1:0]     i_pos,
    input  logic                           i_white,
    input  dtc_pkg::t_map_cfg              i_cfg,
    output logic [dtc_pkg::CH_W-1:0]       o_level
);

    localparam int X_W = dtc_pkg::TURN_W + 3;

    typedef struct packed {
        logic [dtc_pkg::TURN_W-1:0] rem;
        logic [dtc_pkg::Q_W-1:0]    low;
        logic [dtc_pkg::Q_W-1:0]    quo;
    } t_div_state;

    function automatic t_div_state div_step(input t_div_state st,
                                            input logic [dtc_pkg::TURN_W-1:0] turn);
        t_div_state               v;
        logic [dtc_pkg::TURN_W:0] trial;
        v = st;
        for (int j = 0; j < dtc_pkg::DIV_STEPS; j++) begin
            trial = {v.rem, v.low[dtc_pkg::Q_W-1]};
            v.low = {v.low[dtc_pkg::Q_W-2:0], 1'b0};
            if (trial >= {1'b0, turn}) begin
                v.rem = dtc_pkg::TURN_W'(trial - {1'b0, turn});
                v.quo = {v.quo[dtc_pkg::Q_W-2:0], 1'b1};
            end else begin
                v.rem = trial[dtc_pkg::TURN_W-1:0];
                v.quo = {v.quo[dtc_pkg::Q_W-2:0], 1'b0};
            end
        end
        return v;
    endfunction

    logic [X_W-1:0]              w_six_t;
    logic [X_W-1:0]              w_two_t;
    logic [X_W-1:0]              w_three_t;
    logic [X_W-1:0]              w_turn;
    logic [dtc_pkg::TURN_W-1:0]  n_k;
    logic [dtc_pkg::TURN_W-1:0]  r_k;
    logic [dtc_pkg::PROD_W-1:0]  r_prod;
    t_div_state                  n_div [dtc_pkg::DIV_STAGES];
    t_div_state                  r_div [dtc_pkg::DIV_STAGES];
    logic [dtc_pkg::Q_W:0]       w_sum;
    logic [dtc_pkg::CH_W-1:0]    r_level;

    always_comb begin
        w_two_t   = X_W'({i_pos, 1'b0});
        w_six_t   = X_W'({i_pos, 2'b0}) + w_two_t;
        w_three_t = w_two_t + X_W'(i_pos);
        w_turn    = X_W'(i_cfg.turn);
        if (w_six_t < w_turn) begin
            n_k = w_six_t[dtc_pkg::TURN_W-1:0];
        end else if (w_two_t < w_turn) begin
            n_k = i_cfg.turn;
        end else if (w_three_t < X_W'({i_cfg.turn, 1'b0})) begin
            n_k = dtc_pkg::TURN_W'(X_W'({i_cfg.turn, 2'b0}) - w_six_t);
        end else begin
            n_k = '0;
        end

        n_div[0] = div_step(t_div_state'{rem: r_prod[dtc_pkg::PROD_W-1:dtc_pkg::Q_W],
                                         low: r_prod[dtc_pkg::Q_W-1:0],
                                         quo: '0}, i_cfg.turn);
        for (int s = 1; s < dtc_pkg::DIV_STAGES; s++) begin
            n_div[s] = div_step(r_div[s-1], i_cfg.turn);
        end

        w_sum = {1'b0, i_cfg.n_base} + {1'b0, r_div[dtc_pkg::DIV_STAGES-1].quo};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k    <= n_k;
            r_prod <= dtc_pkg::PROD_W'(i_cfg.a_gain) * dtc_pkg::PROD_W'(r_k);
            for (int s = 0; s < dtc_pkg::DIV_STAGES; s++) begin
                r_div[s] <= n_div[s];
            end
            r_level <= i_white ? '1
                               : w_sum[dtc_pkg::ROUND_LSB +: dtc_pkg::CH_W];
        end
    end

    assign o_level = r_level;

endmodule

// ===== hw/rtl/depth_to_hsl_color_map.sv =====
// Depth-to-color map top level: config block, hue front end and three channel pipelines.
// Throughput one request per cycle while the output is not stalled.
// The whole pipeline holds while a result waits on m_axis_tready; bubbles pass through.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
// Config writes taken every cycle; turn and gains settle via r_den, r_p and r_qp after a write.
// Depends on dtc_pkg, dtc_cfg, dtc_hue and dtc_chan.
module depth_to_hsl_color_map (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dtc_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // depth_sample
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dtc_pkg::M_TDATA_W-1:0]     m_axis_tdata,   // red in bits 7:0, green in 15:8, blue in 23:16
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dtc_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [dtc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int LAST = dtc_pkg::PIPE_STAGES - 1;

    dtc_pkg::t_map_cfg                 w_cfg;
    logic                              w_en;
    logic [dtc_pkg::PIPE_STAGES-1:0]   r_vld;
    logic [dtc_pkg::PIPE_STAGES-1:0]   r_white;
    logic [dtc_pkg::TURN_W-1:0]        w_pos_r;
    logic [dtc_pkg::TURN_W-1:0]        w_pos_g;
    logic [dtc_pkg::TURN_W-1:0]        w_pos_b;
    logic [dtc_pkg::CH_W-1:0]          w_red;
    logic [dtc_pkg::CH_W-1:0]          w_green;
    logic [dtc_pkg::CH_W-1:0]          w_blue;

    assign w_en          = !r_vld[LAST] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_white <= {r_white[LAST-1:0], s_axis_tdata[dtc_pkg::DEPTH_BITS-1]};
        end
    end

    dtc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    dtc_hue u_hue (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_depth (s_axis_tdata[dtc_pkg::DEPTH_BITS-1:0]),
        .i_cfg   (w_cfg),
        .o_pos_r (w_pos_r),
        .o_pos_g (w_pos_g),
        .o_pos_b (w_pos_b)
    );

    dtc_chan u_chan_r (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_pos   (w_pos_r),
        .i_white (r_white[LAST-1]),
        .i_cfg   (w_cfg),
        .o_level (w_red)
    );

    dtc_chan u_chan_g (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_pos   (w_pos_g),
        .i_white (r_white[LAST-1]),
        .i_cfg   (w_cfg),
        .o_level (w_green)
    );

    dtc_chan u_chan_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_pos   (w_pos_b),
        .i_white (r_white[LAST-1]),
        .i_cfg   (w_cfg),
        .o_level (w_blue)
    );

    assign m_axis_tvalid = r_vld[LAST];
    assign m_axis_tdata  = {w_blue, w_green, w_red};

    a_white_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_white[LAST] |-> m_axis_tdata == '1)
        else $error("missing-data request not white");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule
